// ===== rtl/ppcc_pkg.sv =====
`timescale 1ns / 1ps
// ppcc_pkg: types, mode codes, matrix coefficients and arithmetic helpers
// for the pixel pair color converter. No dependencies.
package ppcc_pkg;

	// signed accumulator, wide enough for every matrix sum (|sum| < 2^19)
	typedef logic signed [19:0] acc_t;
	typedef logic [7:0]         pix_t;

	// source_format codes
	localparam logic SRC_YUV = 1'b0;
	localparam logic SRC_RGB = 1'b1;

	// color_space codes; the unused code behaves as CS_YUV
	localparam logic [1:0] CS_LUMA = 2'd0;
	localparam logic [1:0] CS_RGB  = 2'd1;
	localparam logic [1:0] CS_YUV  = 2'd2;

	// configuration register indexes
	localparam logic REG_SOURCE_FORMAT = 1'b0;
	localparam logic REG_COLOR_SPACE   = 1'b1;

	localparam logic [2:0] COUNT_LUMA = 3'd2;
	localparam logic [2:0] COUNT_FULL = 3'd6;

	// offsets of the limited-range YUV input
	localparam acc_t Y_OFS = 20'sd16;
	localparam acc_t C_OFS = 20'sd128;

	// BT.601 YUV to RGB
	localparam acc_t K_Y   = 20'sd298;
	localparam acc_t K_RV  = 20'sd409;
	localparam acc_t K_GU  = 20'sd100;
	localparam acc_t K_GV  = 20'sd208;
	localparam acc_t K_BU  = 20'sd516;
	// chroma expansion
	localparam acc_t K_C   = 20'sd293;
	// RGB to YUV
	localparam acc_t K_YR  = 20'sd76;
	localparam acc_t K_YG  = 20'sd150;
	localparam acc_t K_YB  = 20'sd29;
	localparam acc_t K_UR  = 20'sd44;
	localparam acc_t K_UG  = 20'sd85;
	localparam acc_t K_UB  = 20'sd128;
	localparam acc_t K_VR  = 20'sd128;
	localparam acc_t K_VG  = 20'sd108;
	localparam acc_t K_VB  = 20'sd21;

	// zero-extend a sample into the accumulator
	function automatic acc_t ext(input pix_t x);
		return acc_t'({12'd0, x});
	endfunction

	// floor divide by 256
	function automatic acc_t fl8(input acc_t x);
		return x >>> 8;
	endfunction

	// clamp to 0..255
	function automatic pix_t sat8(input acc_t x);
		pix_t res;
		if (x < 0) begin
			res = '0;
		end else if (x > 20'sd255) begin
			res = 8'hFF;
		end else begin
			res = x[7:0];
		end
		return res;
	endfunction

	// RGB source
	function automatic pix_t rgb_luma(input pix_t r, input pix_t g, input pix_t b);
		return sat8(fl8(K_YR * ext(r) + K_YG * ext(g) + K_YB * ext(b)));
	endfunction

	function automatic pix_t rgb_u(input pix_t r, input pix_t g, input pix_t b);
		return sat8(C_OFS + fl8(K_UB * ext(b) - K_UR * ext(r) - K_UG * ext(g)));
	endfunction

	function automatic pix_t rgb_v(input pix_t r, input pix_t g, input pix_t b);
		return sat8(C_OFS + fl8(K_VR * ext(r) - K_VG * ext(g) - K_VB * ext(b)));
	endfunction

	// YUV source; y, u, v are raw samples, offsets removed here
	function automatic pix_t yuv_r(input pix_t y, input pix_t v);
		return sat8(fl8(K_Y * (ext(y) - Y_OFS) + K_RV * (ext(v) - C_OFS)));
	endfunction

	function automatic pix_t yuv_g(input pix_t y, input pix_t u, input pix_t v);
		return sat8(fl8(K_Y * (ext(y) - Y_OFS) - K_GU * (ext(u) - C_OFS)
			- K_GV * (ext(v) - C_OFS)));
	endfunction

	function automatic pix_t yuv_b(input pix_t y, input pix_t u);
		return sat8(fl8(K_Y * (ext(y) - Y_OFS) + K_BU * (ext(u) - C_OFS)));
	endfunction

	function automatic pix_t yuv_luma(input pix_t y);
		return sat8(fl8(K_Y * (ext(y) - Y_OFS)));
	endfunction

	function automatic pix_t yuv_chroma(input pix_t c);
		return sat8(C_OFS + fl8(K_C * (ext(c) - C_OFS)));
	endfunction

endpackage

// ===== rtl/pixel_pair_color_converter.sv =====
`timescale 1ns / 1ps
// Pixel pair color converter: two adjacent pixels in, six bytes out.
// Each accepted beat passes the input register, then the result register.
// Throughput: one pixel pair per clock while the output is not stalled;
// the input register and the result register each hold one beat.
// Reset: pipeline emptied, source_format = RGB, color_space = RGB.
// Depends on ppcc_pkg.
module pixel_pair_color_converter (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] first_c0,
	input  logic [7:0] first_c1,
	input  logic [7:0] first_c2,
	input  logic [7:0] second_c0,
	input  logic [7:0] second_c1,
	input  logic [7:0] second_c2,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte0,
	output logic [7:0] out_byte1,
	output logic [7:0] out_byte2,
	output logic [7:0] out_byte3,
	output logic [7:0] out_byte4,
	output logic [7:0] out_byte5,
	output logic [2:0] byte_count
);

	logic             source_format_q;
	logic [1:0]       color_space_q;

	logic             valid_s1;
	ppcc_pkg::pix_t   pix_s1 [6];
	logic             out_valid_q;
	ppcc_pkg::pix_t   byte_q [6];
	logic [2:0]       count_q;

	ppcc_pkg::pix_t   res [6];
	logic [2:0]       res_count;
	logic             advance;

	// whole pipeline moves unless a result is held by the sink
	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= ppcc_pkg::SRC_RGB;
			color_space_q   <= ppcc_pkg::CS_RGB;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ppcc_pkg::REG_SOURCE_FORMAT: source_format_q <= cfg_data[0];
				ppcc_pkg::REG_COLOR_SPACE:   color_space_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			pix_s1[0] <= first_c0;
			pix_s1[1] <= first_c1;
			pix_s1[2] <= first_c2;
			pix_s1[3] <= second_c0;
			pix_s1[4] <= second_c1;
			pix_s1[5] <= second_c2;
		end
	end

	// conversion
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			res[i] = '0;
		end
		res_count = ppcc_pkg::COUNT_FULL;
		priority if (color_space_q == ppcc_pkg::CS_LUMA) begin
			res_count = ppcc_pkg::COUNT_LUMA;
			if (source_format_q == ppcc_pkg::SRC_YUV) begin
				res[0] = pix_s1[0];
				res[1] = pix_s1[3];
			end else begin
				res[0] = ppcc_pkg::rgb_luma(pix_s1[0], pix_s1[1], pix_s1[2]);
				res[1] = ppcc_pkg::rgb_luma(pix_s1[3], pix_s1[4], pix_s1[5]);
			end
		end else if (source_format_q == ppcc_pkg::SRC_YUV) begin
			if (color_space_q == ppcc_pkg::CS_RGB) begin
				res[0] = ppcc_pkg::yuv_r(pix_s1[0], pix_s1[2]);
				res[1] = ppcc_pkg::yuv_g(pix_s1[0], pix_s1[1], pix_s1[2]);
				res[2] = ppcc_pkg::yuv_b(pix_s1[0], pix_s1[1]);
				res[3] = ppcc_pkg::yuv_r(pix_s1[3], pix_s1[2]);
				res[4] = ppcc_pkg::yuv_g(pix_s1[3], pix_s1[1], pix_s1[2]);
				res[5] = ppcc_pkg::yuv_b(pix_s1[3], pix_s1[1]);
			end else begin
				// chroma shared by both pixels
				res[0] = ppcc_pkg::yuv_luma(pix_s1[0]);
				res[1] = ppcc_pkg::yuv_chroma(pix_s1[1]);
				res[2] = ppcc_pkg::yuv_chroma(pix_s1[2]);
				res[3] = ppcc_pkg::yuv_luma(pix_s1[3]);
				res[4] = res[1];
				res[5] = res[2];
			end
		end else begin
			if (color_space_q == ppcc_pkg::CS_RGB) begin
				for (int i = 0; i < 6; i++) begin
					res[i] = pix_s1[i];
				end
			end else begin
				res[0] = ppcc_pkg::rgb_luma(pix_s1[0], pix_s1[1], pix_s1[2]);
				res[1] = ppcc_pkg::rgb_u(pix_s1[0], pix_s1[1], pix_s1[2]);
				res[2] = ppcc_pkg::rgb_v(pix_s1[0], pix_s1[1], pix_s1[2]);
				res[3] = ppcc_pkg::rgb_luma(pix_s1[3], pix_s1[4], pix_s1[5]);
				res[4] = ppcc_pkg::rgb_u(pix_s1[3], pix_s1[4], pix_s1[5]);
				res[5] = ppcc_pkg::rgb_v(pix_s1[3], pix_s1[4], pix_s1[5]);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			byte_q  <= res;
			count_q <= res_count;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte0  = byte_q[0];
	assign out_byte1  = byte_q[1];
	assign out_byte2  = byte_q[2];
	assign out_byte3  = byte_q[3];
	assign out_byte4  = byte_q[4];
	assign out_byte5  = byte_q[5];
	assign byte_count = count_q;

endmodule

// ===== rtl/ppcc_checker.sv =====
`timescale 1ns / 1ps
// ppcc_checker: port-level assertions for pixel_pair_color_converter,
// attached by the bind at the end of this file. Depends on ppcc_pkg.
module ppcc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte0,
	input logic [7:0] out_byte1,
	input logic [7:0] out_byte2,
	input logic [7:0] out_byte3,
	input logic [7:0] out_byte4,
	input logic [7:0] out_byte5,
	input logic [2:0] byte_count
);

	// held result beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte0)
			&& $stable(out_byte1) && $stable(out_byte5) && $stable(byte_count))
		else $error("stalled result beat changed");

	// input only stalls while a result is held
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
		else $error("input stalled while output free");

	// byte count is one of the two legal values
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_count == ppcc_pkg::COUNT_LUMA)
			|| (byte_count == ppcc_pkg::COUNT_FULL))
		else $error("bad byte count");

	// luma-only beats carry zeros in the unused bytes
	a_luma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_count == ppcc_pkg::COUNT_LUMA |->
			out_byte2 == 8'd0 && out_byte3 == 8'd0
			&& out_byte4 == 8'd0 && out_byte5 == 8'd0)
		else $error("luma beat has nonzero trailing bytes");

	// an accepted beat reaches the output if the output is free while the beat sits in the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !in_stall |=> out_valid)
		else $error("accepted beat did not arrive");

endmodule

bind pixel_pair_color_converter ppcc_checker u_ppcc_checker (.*);

// ===== test/tb_pixel_pair_color_converter.sv =====
`timescale 1ns / 1ps
// tb_pixel_pair_color_converter: self-checking bench for the pixel pair color converter.
// It predicts every output beat for each source format and color space, under random stalls.
// Depends on ppcc_pkg and rtl/pixel_pair_color_converter.sv.
module tb_pixel_pair_color_converter;
	import ppcc_pkg::*;

	// spare color-space code, the block treats it as YUV
	localparam logic [1:0] CS_SPARE = 2'd3;
	localparam int N_PHASES = 9;
	localparam int RANDOM_PER_PHASE = 139;
	localparam int MAX_GAP = 18;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		pix_t first_c0, first_c1, first_c2;
		pix_t second_c0, second_c1, second_c2;
		int   gap;
	} pixel_beat_t;

	typedef struct packed {
		pix_t [5:0] bytes;
		logic [2:0] count;
	} conv_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = REG_SOURCE_FORMAT;
	logic [1:0] cfg_data = 2'd0;
	logic in_valid = 1'b0;
	logic in_stall;
	pix_t first_c0 = '0, first_c1 = '0, first_c2 = '0;
	pix_t second_c0 = '0, second_c1 = '0, second_c2 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	pix_t out_byte0, out_byte1, out_byte2, out_byte3, out_byte4, out_byte5;
	logic [2:0] byte_count;

	pixel_pair_color_converter i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.first_c0   (first_c0),
		.first_c1   (first_c1),
		.first_c2   (first_c2),
		.second_c0  (second_c0),
		.second_c1  (second_c1),
		.second_c2  (second_c2),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte0  (out_byte0),
		.out_byte1  (out_byte1),
		.out_byte2  (out_byte2),
		.out_byte3  (out_byte3),
		.out_byte4  (out_byte4),
		.out_byte5  (out_byte5),
		.byte_count (byte_count)
	);

	always #5 clk = ~clk;

	// bench copy of the two registers
	logic       cfg_src = SRC_RGB;
	logic [1:0] cfg_cs = CS_RGB;

	pixel_beat_t  pending_beats[$];
	conv_result_t conv_expected[$];
	pixel_beat_t  cur_beat;
	int wait_cnt;
	int stall_cnt;
	logic src_burst = 1'b0;
	logic sink_burst = 1'b0;
	int cycle_count = 0;
	int beats_sent = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int unexpected_count = 0;
	int errors = 0;
	logic       phase_src [N_PHASES];
	logic [1:0] phase_cs [N_PHASES];

	function automatic pix_t clip8(input int x);
		pix_t res;
		if (x < 0) begin
			res = 8'd0;
		end else if (x > 255) begin
			res = 8'd255;
		end else begin
			res = x[7:0];
		end
		return res;
	endfunction

	// full-range RGB to YUV, one component each
	function automatic pix_t rgb_to_y(input int r, input int g, input int b);
		return clip8((76 * r + 150 * g + 29 * b) >>> 8);
	endfunction

	function automatic pix_t rgb_to_u(input int r, input int g, input int b);
		return clip8(128 + ((-44 * r - 85 * g + 128 * b) >>> 8));
	endfunction

	function automatic pix_t rgb_to_v(input int r, input int g, input int b);
		return clip8(128 + ((128 * r - 108 * g - 21 * b) >>> 8));
	endfunction

	// expected output beat for one pixel pair under the given setting
	function automatic conv_result_t convert_pair(input pixel_beat_t p, input logic src,
			input logic [1:0] cs);
		conv_result_t res;
		int a0, a1, a2, b0, b1, b2;
		int luma [2];
		int u, v;
		pix_t uo, vo;
		a0 = p.first_c0;
		a1 = p.first_c1;
		a2 = p.first_c2;
		b0 = p.second_c0;
		b1 = p.second_c1;
		b2 = p.second_c2;
		luma[0] = a0 - 16;
		luma[1] = b0 - 16;
		u = a1 - 128;
		v = a2 - 128;
		res.bytes = '0;
		res.count = COUNT_FULL;
		if (cs == CS_LUMA) begin
			// two lumas, upper four bytes stay zero
			res.count = COUNT_LUMA;
			if (src == SRC_YUV) begin
				res.bytes[0] = p.first_c0;
				res.bytes[1] = p.second_c0;
			end else begin
				res.bytes[0] = rgb_to_y(a0, a1, a2);
				res.bytes[1] = rgb_to_y(b0, b1, b2);
			end
		end else if (src == SRC_YUV) begin
			if (cs == CS_RGB) begin
				for (int i = 0; i < 2; i++) begin
					res.bytes[3 * i]     = clip8((298 * luma[i] + 409 * v) >>> 8);
					res.bytes[3 * i + 1] = clip8((298 * luma[i] - 100 * u - 208 * v) >>> 8);
					res.bytes[3 * i + 2] = clip8((298 * luma[i] + 516 * u) >>> 8);
				end
			end else begin
				// full-range YUV, chroma shared by both pixels
				uo = clip8(128 + ((293 * u) >>> 8));
				vo = clip8(128 + ((293 * v) >>> 8));
				for (int i = 0; i < 2; i++) begin
					res.bytes[3 * i]     = clip8((298 * luma[i]) >>> 8);
					res.bytes[3 * i + 1] = uo;
					res.bytes[3 * i + 2] = vo;
				end
			end
		end else if (cs == CS_RGB) begin
			res.bytes = {p.second_c2, p.second_c1, p.second_c0,
				p.first_c2, p.first_c1, p.first_c0};
		end else begin
			res.bytes[0] = rgb_to_y(a0, a1, a2);
			res.bytes[1] = rgb_to_u(a0, a1, a2);
			res.bytes[2] = rgb_to_v(a0, a1, a2);
			res.bytes[3] = rgb_to_y(b0, b1, b2);
			res.bytes[4] = rgb_to_u(b0, b1, b2);
			res.bytes[5] = rgb_to_v(b0, b1, b2);
		end
		return res;
	endfunction

	// random sample, extremes weighted up
	function automatic pix_t rand_sample();
		pix_t res;
		if ($urandom_range(0, 7) == 0) begin
			res = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end else begin
			res = 8'($urandom);
		end
		return res;
	endfunction

	task automatic queue_beat(input pix_t a0, input pix_t a1, input pix_t a2,
			input pix_t b0, input pix_t b1, input pix_t b2);
		pixel_beat_t beat;
		if ($urandom_range(0, 24) == 0) begin
			src_burst = !src_burst;
		end
		beat.first_c0 = a0;
		beat.first_c1 = a1;
		beat.first_c2 = a2;
		beat.second_c0 = b0;
		beat.second_c1 = b1;
		beat.second_c2 = b2;
		beat.gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
		pending_beats.push_back(beat);
	endtask

	task automatic note_mismatch(input string field, input int want, input int got);
		mismatch_count++;
		errors++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
		end
	endtask

	task automatic check_result();
		conv_result_t want, got;
		got.bytes = {out_byte5, out_byte4, out_byte3, out_byte2, out_byte1, out_byte0};
		got.count = byte_count;
		if (conv_expected.size() == 0) begin
			unexpected_count++;
			errors++;
			if (unexpected_count <= 10) begin
				$display("%0t: output beat with nothing expected", $realtime);
			end
			return;
		end
		want = conv_expected.pop_front();
		results_checked++;
		for (int i = 0; i < 6; i++) begin
			if (got.bytes[i] !== want.bytes[i]) begin
				note_mismatch($sformatf("out_byte%0d", i), want.bytes[i], got.bytes[i]);
			end
		end
		if (got.count !== want.count) begin
			note_mismatch("byte_count", want.count, got.count);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_beats.size() != 0 || in_valid || conv_expected.size() != 0);
	endtask

	// input driver: one beat per pending entry, after its gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			wait_cnt = 0;
		end else begin
			if (in_valid && !in_stall) begin
				conv_expected.push_back(convert_pair(cur_beat, cfg_src, cfg_cs));
				beats_sent++;
			end
			if (!(in_valid && in_stall)) begin
				if (pending_beats.size() != 0 && wait_cnt >= pending_beats[0].gap) begin
					cur_beat = pending_beats.pop_front();
					first_c0 <= cur_beat.first_c0;
					first_c1 <= cur_beat.first_c1;
					first_c2 <= cur_beat.first_c2;
					second_c0 <= cur_beat.second_c0;
					second_c1 <= cur_beat.second_c1;
					second_c2 <= cur_beat.second_c2;
					in_valid <= 1'b1;
					wait_cnt = 0;
				end else begin
					if (pending_beats.size() != 0) begin
						wait_cnt++;
					end
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: random stall per result, then check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_cnt = 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_result();
				if ($urandom_range(0, 24) == 0) begin
					sink_burst = !sink_burst;
				end
				stall_cnt = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
			end else if (out_valid && stall_cnt > 0) begin
				stall_cnt--;
			end
			out_stall <= (stall_cnt > 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, conv_expected.size());
			$display("tb_pixel_pair_color_converter failed");
			$finish;
		end
	end

	initial begin
		// reset setting first, then every other code, then back to RGB passthrough
		phase_src = '{SRC_RGB, SRC_YUV, SRC_YUV, SRC_YUV, SRC_YUV,
			SRC_RGB, SRC_RGB, SRC_RGB, SRC_RGB};
		phase_cs = '{CS_RGB, CS_LUMA, CS_RGB, CS_YUV, CS_SPARE,
			CS_LUMA, CS_YUV, CS_SPARE, CS_RGB};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph > 0) begin
				wait_idle();
				write_reg(REG_SOURCE_FORMAT, {1'($urandom_range(0, 1)), phase_src[ph]});
				write_reg(REG_COLOR_SPACE, phase_cs[ph]);
				@(posedge clk);
				cfg_wr_en <= 1'b0;
				cfg_src = phase_src[ph];
				cfg_cs = phase_cs[ph];
				@(negedge clk);
			end
			// corner beats: black, white, alternating extremes (clamps both ways)
			if (ph < 8) begin
				queue_beat(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				queue_beat(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
				queue_beat(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				queue_beat(rand_sample(), rand_sample(), rand_sample(),
					rand_sample(), rand_sample(), rand_sample());
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (conv_expected.size() != 0) begin
			errors++;
		end
		$display("converted %0d pixel pairs over %0d register settings, %0d results checked",
			beats_sent, N_PHASES, results_checked);
		$display("%0d mismatching fields, %0d unexpected output beats",
			mismatch_count, unexpected_count);
		if (errors == 0) begin
			$display("tb_pixel_pair_color_converter passed");
		end else begin
			$display("tb_pixel_pair_color_converter failed");
		end
		$finish;
	end

endmodule
